// ----- rtl/dqp_pkg.sv -----
// Shared types and constants for the DNS query stream parser.
`timescale 1ns / 1ps
`default_nettype none
package dqp_pkg;

	localparam int BYTE_W      = 8;
	localparam int WORD_W      = 16;
	localparam int KIND_W      = 3;
	localparam int LABEL_NUM_W = 2;
	localparam int HDR_LEN     = 12;
	localparam int POS_W       = 4;
	localparam int REM_W       = 6;

	localparam int LABEL_LIMIT_DEF     = 63;
	localparam int LABELS_PER_NAME_DEF = 3;

	typedef enum logic [KIND_W-1:0] {
		KIND_HEADER   = 3'd0,
		KIND_LABEL    = 3'd1,
		KIND_QUESTION = 3'd2,
		KIND_ERROR    = 3'd3,
		KIND_DONE     = 3'd4
	} kind_t;

	typedef struct packed {
		kind_t                  kind;
		logic [WORD_W-1:0]      ident_or_class;
		logic [WORD_W-1:0]      flags_or_type;
		logic [WORD_W-1:0]      question_total;
		logic [WORD_W-1:0]      answer_total;
		logic [WORD_W-1:0]      authority_total;
		logic [WORD_W-1:0]      additional_total;
		logic [LABEL_NUM_W-1:0] label_number;
		logic [BYTE_W-1:0]      label_byte;
		logic [WORD_W-1:0]      question_number;
	} result_t;

	// parser -> result stage request
	typedef struct packed {
		logic    valid;
		logic    two;     // a message done result follows this one
		result_t item;
	} res_req_t;

	// result stage -> parser / top status
	typedef struct packed {
		logic take_ok;
		logic done_pend;
	} res_stat_t;

endpackage
`default_nettype wire

// ----- rtl/dqp_if.sv -----
// Query byte and result channel interfaces.
`timescale 1ns / 1ps
`default_nettype none
interface dqp_query_if;
	logic                       valid;
	logic                       ready;
	logic [dqp_pkg::BYTE_W-1:0] data_byte;
	logic                       message_start;

	modport source(output valid, data_byte, message_start, input ready);
	modport sink(input valid, data_byte, message_start, output ready);
endinterface

interface dqp_result_if;
	logic                            valid;
	logic                            ready;
	logic [dqp_pkg::KIND_W-1:0]      kind;
	logic [dqp_pkg::WORD_W-1:0]      ident_or_class;
	logic [dqp_pkg::WORD_W-1:0]      flags_or_type;
	logic [dqp_pkg::WORD_W-1:0]      question_total;
	logic [dqp_pkg::WORD_W-1:0]      answer_total;
	logic [dqp_pkg::WORD_W-1:0]      authority_total;
	logic [dqp_pkg::WORD_W-1:0]      additional_total;
	logic [dqp_pkg::LABEL_NUM_W-1:0] label_number;
	logic [dqp_pkg::BYTE_W-1:0]      label_byte;
	logic [dqp_pkg::WORD_W-1:0]      question_number;

	modport source(output valid, kind, ident_or_class, flags_or_type, question_total,
		answer_total, authority_total, additional_total, label_number, label_byte,
		question_number, input ready);
	modport sink(input valid, kind, ident_or_class, flags_or_type, question_total,
		answer_total, authority_total, additional_total, label_number, label_byte,
		question_number, output ready);
endinterface
`default_nettype wire

// ----- rtl/dqp_parse.sv -----
// Input register and per-byte header/question parsing state machine.
`timescale 1ns / 1ps
`default_nettype none
module dqp_parse #(
	parameter int LABEL_LIMIT     = dqp_pkg::LABEL_LIMIT_DEF,
	parameter int LABELS_PER_NAME = dqp_pkg::LABELS_PER_NAME_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	dqp_query_if.sink              query,
	input  wire dqp_pkg::res_stat_t stat,
	output dqp_pkg::res_req_t      req
);

	localparam int LW = $clog2(LABELS_PER_NAME + 1);
	localparam int BW = dqp_pkg::BYTE_W;
	localparam int WW = dqp_pkg::WORD_W;
	localparam int PW = dqp_pkg::POS_W;
	localparam int RW = dqp_pkg::REM_W;
	localparam int HDR_LAST = dqp_pkg::HDR_LEN - 1;

	typedef enum logic [2:0] {
		PH_IDLE, PH_HEADER, PH_LEN, PH_LABEL, PH_CLASS, PH_TYPE, PH_ERROR
	} phase_t;

	// input register
	logic          valid_s1;
	logic [BW-1:0] byte_s1;
	logic          start_s1;

	phase_t        phase_q, phase_d;
	logic [PW-1:0] pos_q, pos_d;
	logic [LW-1:0] label_q, label_d;
	logic [RW-1:0] rem_q, rem_d;
	logic [WW-1:0] qleft_q, qleft_d;
	logic [WW-1:0] qidx_q, qidx_d;
	logic [BW-1:0] high_q, high_d;
	logic [WW-1:0] class_q, class_d;
	logic [BW-1:0] hdr_q [HDR_LAST];

	phase_t          ph;
	logic [PW-1:0]   pos;
	logic            hdr_we;
	logic [LW-1:0]   label_inc;
	logic [RW-1:0]   rem_dec;
	logic [WW-1:0]   qleft_dec;
	logic            need;
	logic            two;
	dqp_pkg::result_t item;
	logic            fire;
	logic            accept;

	assign fire        = valid_s1 && (!need || stat.take_ok);
	assign query.ready = !valid_s1 || fire;
	assign accept      = query.valid && query.ready;

	assign label_inc = label_q + LW'(1);
	assign rem_dec   = (rem_q != '0) ? rem_q - RW'(1) : '0;
	assign qleft_dec = qleft_q - WW'(1);

	always_comb begin
		ph        = start_s1 ? PH_HEADER : phase_q;
		pos       = start_s1 ? '0 : pos_q;
		phase_d   = ph;
		pos_d     = pos;
		label_d   = label_q;
		rem_d     = rem_q;
		qleft_d   = qleft_q;
		qidx_d    = qidx_q;
		high_d    = high_q;
		class_d   = class_q;
		hdr_we    = 1'b0;
		need      = 1'b0;
		two       = 1'b0;
		item      = '0;
		case (ph)
			PH_HEADER: begin
				if (pos < PW'(HDR_LAST)) begin
					hdr_we = 1'b1;
					pos_d  = pos + PW'(1);
				end else begin
					need                  = 1'b1;
					item.kind             = dqp_pkg::KIND_HEADER;
					item.ident_or_class   = {hdr_q[0], hdr_q[1]};
					item.flags_or_type    = {hdr_q[2], hdr_q[3]};
					item.question_total   = {hdr_q[4], hdr_q[5]};
					item.answer_total     = {hdr_q[6], hdr_q[7]};
					item.authority_total  = {hdr_q[8], hdr_q[9]};
					item.additional_total = {hdr_q[10], byte_s1};
					qleft_d = {hdr_q[4], hdr_q[5]};
					qidx_d  = '0;
					pos_d   = '0;
					label_d = '0;
					if ({hdr_q[4], hdr_q[5]} == '0) begin
						two     = 1'b1;
						phase_d = PH_IDLE;
					end else begin
						phase_d = PH_LEN;
					end
				end
			end
			PH_LEN: begin
				if (byte_s1 >= BW'(LABEL_LIMIT)) begin
					need                 = 1'b1;
					item.kind            = dqp_pkg::KIND_ERROR;
					item.label_number    = dqp_pkg::LABEL_NUM_W'(label_q);
					item.question_number = qidx_q;
					phase_d              = PH_ERROR;
				end else if (byte_s1 == '0) begin
					label_d = label_inc;
					if (label_inc >= LW'(LABELS_PER_NAME)) begin
						phase_d = PH_CLASS;
						pos_d   = '0;
					end else begin
						phase_d = PH_LEN;
					end
				end else begin
					rem_d   = byte_s1[RW-1:0];
					phase_d = PH_LABEL;
				end
			end
			PH_LABEL: begin
				need                 = 1'b1;
				item.kind            = dqp_pkg::KIND_LABEL;
				item.label_number    = dqp_pkg::LABEL_NUM_W'(label_q);
				item.label_byte      = byte_s1;
				item.question_number = qidx_q;
				rem_d                = rem_dec;
				if (rem_dec == '0) begin
					label_d = label_inc;
					if (label_inc >= LW'(LABELS_PER_NAME)) begin
						phase_d = PH_CLASS;
						pos_d   = '0;
					end else begin
						phase_d = PH_LEN;
					end
				end
			end
			PH_CLASS: begin
				if (pos == '0) begin
					high_d = byte_s1;
					pos_d  = PW'(1);
				end else begin
					class_d = {high_q, byte_s1};
					pos_d   = '0;
					phase_d = PH_TYPE;
				end
			end
			PH_TYPE: begin
				if (pos == '0) begin
					high_d = byte_s1;
					pos_d  = PW'(1);
				end else begin
					need                 = 1'b1;
					item.kind            = dqp_pkg::KIND_QUESTION;
					item.ident_or_class  = class_q;
					item.flags_or_type   = {high_q, byte_s1};
					item.question_number = qidx_q;
					pos_d   = '0;
					qleft_d = qleft_dec;
					qidx_d  = qidx_q + WW'(1);
					label_d = '0;
					if (qleft_dec == '0) begin
						two     = 1'b1;
						phase_d = PH_IDLE;
					end else begin
						phase_d = PH_LEN;
					end
				end
			end
			default: begin
				// idle or error: byte dropped
			end
		endcase
	end

	assign req.valid = fire && need;
	assign req.two   = two;
	assign req.item  = item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			phase_q  <= PH_IDLE;
			pos_q    <= '0;
			label_q  <= '0;
			rem_q    <= '0;
			qleft_q  <= '0;
			qidx_q   <= '0;
			high_q   <= '0;
			class_q  <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (fire) begin
				valid_s1 <= 1'b0;
			end
			if (fire) begin
				phase_q <= phase_d;
				pos_q   <= pos_d;
				label_q <= label_d;
				rem_q   <= rem_d;
				qleft_q <= qleft_d;
				qidx_q  <= qidx_d;
				high_q  <= high_d;
				class_q <= class_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1  <= query.data_byte;
			start_s1 <= query.message_start;
		end
		if (fire && hdr_we) begin
			hdr_q[pos] <= byte_s1;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/dqp_result.sv -----
// Output register with a pending message-done slot.
`timescale 1ns / 1ps
`default_nettype none
module dqp_result (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire dqp_pkg::res_req_t req,
	output dqp_pkg::res_stat_t     stat,
	dqp_result_if.source           result
);

	dqp_pkg::result_t out_q;
	dqp_pkg::result_t done_item;
	logic             valid_q;
	logic             pend_q;
	logic             out_free;

	assign out_free     = !valid_q || result.ready;
	assign stat.take_ok = out_free && !pend_q;
	assign stat.done_pend = pend_q;

	always_comb begin
		done_item      = '0;
		done_item.kind = dqp_pkg::KIND_DONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pend_q  <= 1'b0;
		end else if (out_free) begin
			if (pend_q) begin
				valid_q <= 1'b1;
				pend_q  <= 1'b0;
			end else begin
				valid_q <= req.valid;
				pend_q  <= req.valid && req.two;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= pend_q ? done_item : req.item;
		end
	end

	assign result.valid            = valid_q;
	assign result.kind             = out_q.kind;
	assign result.ident_or_class   = out_q.ident_or_class;
	assign result.flags_or_type    = out_q.flags_or_type;
	assign result.question_total   = out_q.question_total;
	assign result.answer_total     = out_q.answer_total;
	assign result.authority_total  = out_q.authority_total;
	assign result.additional_total = out_q.additional_total;
	assign result.label_number     = out_q.label_number;
	assign result.label_byte       = out_q.label_byte;
	assign result.question_number  = out_q.question_number;

endmodule
`default_nettype wire

// ----- rtl/dns_query_stream_parser.sv -----
// Top level of the DNS query stream parser.
// Takes one message byte per request, one request per cycle unless a byte
// that produces a result is held in the input register. A byte is registered,
// parsed against the header/question state and its result lands in the output
// register. A header result with a zero question count, or the question done
// result of the last question, is followed by a message done result from the
// same output register in the cycle after it is taken. Bytes that produce no
// result keep flowing while the output side stalls; a byte that produces a
// result waits for the output register to free up.
`timescale 1ns / 1ps
`default_nettype none
module dns_query_stream_parser #(
	parameter int LABEL_LIMIT     = dqp_pkg::LABEL_LIMIT_DEF,
	parameter int LABELS_PER_NAME = dqp_pkg::LABELS_PER_NAME_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	dqp_query_if.sink    query,
	dqp_result_if.source result
);

	dqp_pkg::res_req_t  req;
	dqp_pkg::res_stat_t stat;

	dqp_parse #(
		.LABEL_LIMIT    (LABEL_LIMIT),
		.LABELS_PER_NAME(LABELS_PER_NAME)
	) u_parse (
		.clk   (clk),
		.arst_n(arst_n),
		.query (query),
		.stat  (stat),
		.req   (req)
	);

	dqp_result u_result (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.stat  (stat),
		.result(result)
	);

	// a pending done always sits behind a visible result
	a_pend_valid: assert property (@(posedge clk) disable iff (!arst_n)
		stat.done_pend |-> result.valid)
		else $error("done pending with empty output register");

	// parser never hands over a result the output stage cannot take
	a_req_taken: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid |-> stat.take_ok)
		else $error("result request while output stage busy");

	// pending done goes out right after the current result is taken
	a_done_next: assert property (@(posedge clk) disable iff (!arst_n)
		(stat.done_pend && result.valid && result.ready) |=>
		(result.valid && result.kind == dqp_pkg::KIND_DONE))
		else $error("message done result not issued after pending");

endmodule
`default_nettype wire
